// File: rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, types and the banned pattern table for the byte scanner.
// ----------------------------------------------------------------------------
package bps_pkg;

  // Number of earlier bytes held in the history window.
  localparam int HIST_DEPTH = 22;
  // Number of banned patterns.
  localparam int PAT_COUNT  = 12;
  // Longest pattern, in bytes: the window plus the current byte.
  localparam int PAT_MAX    = HIST_DEPTH + 1;
  localparam int PAT_BITS   = PAT_MAX * 8;

  // Width of the result index (0 for clean, 1 to PAT_COUNT otherwise).
  localparam int IDX_W = 4;

  typedef logic [7:0]                  bps_byte_t;
  typedef logic [HIST_DEPTH-1:0][7:0]  bps_win_t;
  typedef logic [PAT_COUNT-1:0]        bps_mask_t;
  typedef logic [IDX_W-1:0]            bps_idx_t;

  // Control handed to every cell of the history chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } bps_cell_ctl_t;

  // Pattern text, right-aligned: the last character sits in bits [7:0],
  // the character k places before it in bits [8k+7:8k].
  localparam logic [PAT_BITS-1:0] PAT_TEXT [PAT_COUNT] = '{
    PAT_BITS'("system("),
    PAT_BITS'("execl("),
    PAT_BITS'("execle("),
    PAT_BITS'("execlp("),
    PAT_BITS'("execv("),
    PAT_BITS'("execve("),
    PAT_BITS'("execvp("),
    PAT_BITS'("fork("),
    PAT_BITS'("popen("),
    PAT_BITS'("__asm__"),
    PAT_BITS'("asm("),
    PAT_BITS'("#include <sys/ptrace.h>")
  };

  // Pattern lengths in bytes, in list order.
  localparam int PAT_LEN [PAT_COUNT] = '{7, 6, 7, 7, 6, 7, 7, 5, 6, 7, 4, 23};

endpackage

// File: rtl/bps_cell.sv
// ----------------------------------------------------------------------------
// bps_cell
// One stage of the history chain: holds one byte and passes it on.
// ----------------------------------------------------------------------------
module bps_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bps_pkg::bps_cell_ctl_t ctl,
  input  bps_pkg::bps_byte_t     byte_in,
  output bps_pkg::bps_byte_t     byte_out
);

  import bps_pkg::*;

  bps_byte_t byte_r;
  bps_byte_t byte_nxt;

  // Clearing wins over shifting, so a final byte leaves an empty window.
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule

// File: rtl/bps_match.sv
// ----------------------------------------------------------------------------
// bps_match
// Parallel compare of all banned patterns ending at the current byte.
// ----------------------------------------------------------------------------
module bps_match (
  input  bps_pkg::bps_byte_t cur_byte,
  input  bps_pkg::bps_win_t  win,
  output bps_pkg::bps_mask_t hit
);

  import bps_pkg::*;

  // Each pattern checks its last character against the current byte and
  // the earlier characters against the window, newest entry first.
  always_comb begin
    logic ok;
    for (int p = 0; p < PAT_COUNT; p++) begin
      ok = (cur_byte == PAT_TEXT[p][7:0]);
      for (int k = 1; k < PAT_MAX; k++) begin
        if (k < PAT_LEN[p]) begin
          ok = ok && (win[k-1] == PAT_TEXT[p][k*8 +: 8]);
        end
      end
      hit[p] = ok;
    end
  end

endmodule

// File: rtl/banned_pattern_byte_scanner.sv
// ----------------------------------------------------------------------------
// banned_pattern_byte_scanner
// Streams a text one byte per transfer and flags banned call patterns.
// ----------------------------------------------------------------------------
// Input channel: in_text_byte with in_is_final marking the last byte of a
// text; a transfer happens when in_valid is high and in_stall is low.
// A zero byte ends the text: it and all later bytes up to the final one
// are not scanned.
// Result channel: one transfer per text, carrying out_match_index (lowest
// numbered banned pattern seen, 0 when clean) and out_is_safe.
// Throughput is one byte per cycle while in_stall is low. The history
// window is a chain of 22 byte cells shifted on each scanned byte, and
// all twelve pattern compares run in parallel on it, so the whole scan
// of a byte is combinational. The result is presented on the cycle after
// the final byte's transfer, from an output register.
// When the receiver stalls, non-final bytes keep flowing; only a final
// byte is held back while an earlier result still waits in the register.
// Reset (rst_n low, synchronous) empties the window, clears the found mask
// and terminator flag and drops out_valid.
// ----------------------------------------------------------------------------
module banned_pattern_byte_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bps_pkg::bps_byte_t  in_text_byte,
  input  logic                in_is_final,
  output logic                out_valid,
  input  logic                out_stall,
  output bps_pkg::bps_idx_t   out_match_index,
  output logic                out_is_safe
);

  import bps_pkg::*;

  logic          in_xfer;
  logic          scan_en;
  bps_cell_ctl_t cell_ctl;
  bps_win_t      win;
  bps_mask_t     hit;
  bps_mask_t     found_r;
  bps_mask_t     found_nxt;
  logic          term_r;
  logic          term_nxt;
  bps_idx_t      first_idx;
  logic          out_valid_r;
  logic          out_valid_nxt;
  bps_idx_t      out_idx_r;
  logic          out_safe_r;

  // A final byte waits only while an untaken result sits in the register.
  assign in_stall = out_valid_r && out_stall && in_is_final;
  assign in_xfer  = in_valid && !in_stall;
  assign scan_en  = in_xfer && !term_r && (in_text_byte != '0);

  assign cell_ctl.shift = scan_en;
  assign cell_ctl.clear = in_xfer && in_is_final;

  // History chain: cell 0 takes the new byte, each later cell its neighbor.
  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    bps_byte_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = in_text_byte;
    end else begin : g_body
      assign cell_in = win[i-1];
    end
    bps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .byte_in  (cell_in),
      .byte_out (win[i])
    );
  end

  bps_match u_match (
    .cur_byte (in_text_byte),
    .win      (win),
    .hit      (hit)
  );

  // Sticky found mask and terminator flag, including the current byte.
  always_comb begin
    found_nxt = found_r | (scan_en ? hit : '0);
    term_nxt  = term_r;
    if (in_xfer && (in_text_byte == '0)) begin
      term_nxt = 1'b1;
    end
  end

  // Lowest-numbered pattern in the mask, 1-based.
  always_comb begin
    first_idx = '0;
    for (int i = PAT_COUNT - 1; i >= 0; i--) begin
      if (found_nxt[i]) begin
        first_idx = IDX_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
      term_r  <= 1'b0;
    end else if (in_xfer && in_is_final) begin
      found_r <= '0;
      term_r  <= 1'b0;
    end else begin
      found_r <= found_nxt;
      term_r  <= term_nxt;
    end
  end

  // Output register: loads on a final transfer, empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer && in_is_final) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_is_final) begin
      out_idx_r  <= first_idx;
      out_safe_r <= (found_nxt == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_idx_r;
  assign out_is_safe     = out_safe_r;

endmodule

// File: rtl/bps_chk.sv
// ----------------------------------------------------------------------------
// bps_chk
// Port-level checks for the banned pattern byte scanner, bound to the top.
// ----------------------------------------------------------------------------
module bps_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bps_pkg::bps_byte_t in_text_byte,
  input logic               in_is_final,
  input logic               out_valid,
  input logic               out_stall,
  input bps_pkg::bps_idx_t  out_match_index,
  input logic               out_is_safe
);

  import bps_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_index)
      && $stable(out_is_safe))
    else $error("stalled result changed");

  // The safe flag and the index agree.
  a_safe_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_safe == (out_match_index == '0)))
    else $error("safe flag disagrees with match index");

  // The index never exceeds the pattern count.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_index <= IDX_W'(PAT_COUNT)))
    else $error("match index out of range");

  // A final transfer yields a result on the next cycle.
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_final |=> out_valid)
    else $error("no result after final byte");

  // Input is held back only for a final byte behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && in_is_final)
    else $error("input stalled without cause");

endmodule

bind banned_pattern_byte_scanner bps_chk u_bps_chk (.*);
